// ----- rtl/ogpt_pkg.sv -----
// Package with the shared types, constants and helper functions of the Ogg granule tracker.
`timescale 1ns / 1ps
package ogpt_pkg;

    localparam int DEF_MAX_STREAMS     = 16;
    localparam int DEF_META_SCAN_LIMIT = 4096;
    localparam int TAG_LEN             = 6;
    localparam int TAG_MIN_PAYLOAD     = 8;
    localparam int HDR_LAST            = 26;

    // Command codes carried on the input channel.
    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_SEGMENTS = 3'd1,
        PH_PAYLOAD  = 3'd2
    } t_phase;

    typedef enum logic [2:0] {
        T_IDLE = 3'd0,
        T_LRD  = 3'd1,
        T_LCMP = 3'd2,
        T_MRD  = 3'd3,
        T_MCMP = 3'd4,
        T_OVR  = 3'd5,
        T_ERD  = 3'd6,
        T_EOUT = 3'd7
    } t_tbl_state;

    // One completed page handed from the parser to the stream table.
    typedef struct packed {
        logic [31:0] serial;
        logic [63:0] granule;
    } t_page_evt;

    // One report line.
    typedef struct packed {
        logic [31:0] stream_serial;
        logic [63:0] duration_samples;
        logic        is_overall;
        logic        last_of_report;
        logic        table_overflowed;
        logic        parse_halted;
    } t_result;

    // Capture pattern "OggS".
    function automatic logic [7:0] capture_byte(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0:    v = 8'h4F;
            2'd1:    v = 8'h67;
            2'd2:    v = 8'h67;
            default: v = 8'h53;
        endcase
        return v;
    endfunction

    // Metadata tag "ECMETA".
    function automatic logic [7:0] tag_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h45;
            3'd1:    v = 8'h43;
            3'd2:    v = 8'h4D;
            3'd3:    v = 8'h45;
            3'd4:    v = 8'h54;
            default: v = 8'h41;
        endcase
        return v;
    endfunction

    // Duration of a track from the start granule, or the last granule if not above it.
    function automatic logic [63:0] adjusted(input logic [63:0] last,
                                             input logic [63:0] start);
        return (last > start) ? (last - start) : last;
    endfunction

endpackage

// ----- rtl/ogpt_parser.sv -----
// Byte-level Ogg page parser that tracks header fields, metadata and start granule.
`timescale 1ns / 1ps
module ogpt_parser #(
    parameter int META_SCAN_LIMIT = ogpt_pkg::DEF_META_SCAN_LIMIT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    output logic                o_evt_valid,
    output ogpt_pkg::t_page_evt o_evt,
    output logic [63:0]         o_start_granule,
    output logic                o_halted
);
    import ogpt_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_granule, n_granule;
    logic [31:0] r_serial, n_serial;
    logic [7:0]  r_seg, n_seg;
    logic [16:0] r_size, n_size;
    logic [16:0] r_left, n_left;
    logic        r_tag, n_tag;
    logic        r_meta_found, n_meta_found;
    logic [31:0] r_meta_serial, n_meta_serial;
    logic [63:0] r_start, n_start;
    logic        r_start_found, n_start_found;
    logic        r_halted, n_halted;
    logic [4:0]  hdr_cnt;

    // Per-byte parsing and page completion.
    always_comb begin
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_granule     = r_granule;
        n_serial      = r_serial;
        n_seg         = r_seg;
        n_size        = r_size;
        n_left        = r_left;
        n_tag         = r_tag;
        n_meta_found  = r_meta_found;
        n_meta_serial = r_meta_serial;
        n_start       = r_start;
        n_start_found = r_start_found;
        n_halted      = r_halted;
        o_evt_valid   = 1'b0;
        hdr_cnt       = (r_cnt > 5'(HDR_LAST)) ? 5'd0 : r_cnt;
        if (i_take && !r_halted) begin
            unique case (r_phase)
                PH_SEGMENTS: begin
                    n_size = r_size + {9'd0, i_byte};
                    n_seg  = r_seg - 8'd1;
                    if (r_seg == 8'd1) begin
                        n_cnt = 5'd0;
                        if (n_size == 17'd0) begin
                            n_phase = PH_HEADER;
                        end else begin
                            n_left  = n_size;
                            n_tag   = 1'b1;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (r_cnt < 5'(TAG_LEN)) begin
                        if (i_byte != tag_byte(r_cnt[2:0])) begin
                            n_tag = 1'b0;
                        end
                        n_cnt = r_cnt + 5'd1;
                    end
                    n_left = r_left - 17'd1;
                    if (r_left == 17'd1) begin
                        // The page ends with this byte.
                        if (!r_meta_found && n_tag && r_size >= 17'(TAG_MIN_PAYLOAD)
                            && r_size < 17'(META_SCAN_LIMIT)) begin
                            n_meta_found  = 1'b1;
                            n_meta_serial = r_serial;
                        end
                        if (!r_start_found && r_granule != 64'd0) begin
                            n_start_found = 1'b1;
                            n_start       = r_granule;
                        end
                        o_evt_valid = !(n_meta_found && r_serial == n_meta_serial);
                        n_phase     = PH_HEADER;
                        n_cnt       = 5'd0;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                    if (hdr_cnt < 5'd4 && i_byte != capture_byte(hdr_cnt[1:0])) begin
                        n_halted = 1'b1;
                        n_cnt    = hdr_cnt;
                    end else begin
                        if (hdr_cnt >= 5'd6 && hdr_cnt <= 5'd13) begin
                            n_granule = {i_byte, r_granule[63:8]};
                        end else if (hdr_cnt >= 5'd14 && hdr_cnt <= 5'd17) begin
                            n_serial = {i_byte, r_serial[31:8]};
                        end
                        if (hdr_cnt == 5'(HDR_LAST)) begin
                            n_cnt  = 5'd0;
                            n_seg  = i_byte;
                            n_size = 17'd0;
                            if (i_byte != 8'd0) begin
                                n_phase = PH_SEGMENTS;
                            end
                        end else begin
                            n_cnt = hdr_cnt + 5'd1;
                        end
                    end
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_cnt         <= 5'd0;
            r_granule     <= 64'd0;
            r_serial      <= 32'd0;
            r_seg         <= 8'd0;
            r_size        <= 17'd0;
            r_left        <= 17'd0;
            r_tag         <= 1'b0;
            r_meta_found  <= 1'b0;
            r_meta_serial <= 32'd0;
            r_start       <= 64'd0;
            r_start_found <= 1'b0;
            r_halted      <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_cnt         <= n_cnt;
            r_granule     <= n_granule;
            r_serial      <= n_serial;
            r_seg         <= n_seg;
            r_size        <= n_size;
            r_left        <= n_left;
            r_tag         <= n_tag;
            r_meta_found  <= n_meta_found;
            r_meta_serial <= n_meta_serial;
            r_start       <= n_start;
            r_start_found <= n_start_found;
            r_halted      <= n_halted;
        end
    end

    assign o_evt.serial    = r_serial;
    assign o_evt.granule   = r_granule;
    assign o_start_granule = r_start;
    assign o_halted        = r_halted;

endmodule

// ----- rtl/ogpt_table.sv -----
// Stream table in synchronous memories, with page update and report sequencing.
`timescale 1ns / 1ps
module ogpt_table #(
    parameter int MAX_STREAMS = ogpt_pkg::DEF_MAX_STREAMS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_evt_valid,
    input  ogpt_pkg::t_page_evt i_evt,
    input  logic                i_report,
    input  logic [63:0]         i_start_granule,
    input  logic                i_halted,
    output logic                o_busy,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ogpt_pkg::t_result   o_result
);
    import ogpt_pkg::*;

    localparam int CW = $clog2(MAX_STREAMS + 1);
    localparam int IW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

    logic [31:0] mem_serial  [MAX_STREAMS];
    logic [63:0] mem_granule [MAX_STREAMS];

    t_tbl_state  r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic        r_ovf, n_ovf;
    logic [63:0] r_max, n_max;
    t_page_evt   r_evt, n_evt;
    logic        r_ovalid, n_ovalid;
    t_result     r_res, n_res;
    logic [31:0] r_rd_serial;
    logic [63:0] r_rd_granule;
    logic        rd_en, wr_ser, wr_gran;
    logic [IW-1:0] wr_addr;
    logic        out_free;
    logic        at_end;

    assign out_free = !r_ovalid || !i_out_stall;
    assign at_end   = (r_idx == r_cnt);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: begin
                if (i_evt_valid) begin
                    n_state = T_LRD;
                end else if (i_report) begin
                    n_state = T_MRD;
                end
            end
            T_LRD:  n_state = at_end ? T_IDLE : T_LCMP;
            T_LCMP: n_state = (r_rd_serial == r_evt.serial) ? T_IDLE : T_LRD;
            T_MRD:  n_state = at_end ? T_OVR : T_MCMP;
            T_MCMP: n_state = T_MRD;
            T_OVR: begin
                if (out_free) begin
                    n_state = (r_cnt == '0) ? T_IDLE : T_ERD;
                end
            end
            T_ERD:  n_state = T_EOUT;
            T_EOUT: begin
                if (out_free) begin
                    n_state = (r_idx + CW'(1) == r_cnt) ? T_IDLE : T_ERD;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    // Datapath actions of each state.
    always_comb begin
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_max    = r_max;
        n_evt    = r_evt;
        n_res    = r_res;
        n_ovalid = r_ovalid && i_out_stall;
        rd_en    = 1'b0;
        wr_ser   = 1'b0;
        wr_gran  = 1'b0;
        wr_addr  = r_idx[IW-1:0];
        unique case (r_state)
            T_IDLE: begin
                if (i_evt_valid) begin
                    n_evt = i_evt;
                    n_idx = '0;
                end else if (i_report) begin
                    n_idx = '0;
                    n_max = 64'd0;
                end
            end
            T_LRD: begin
                if (at_end) begin
                    if (r_cnt == CW'(MAX_STREAMS)) begin
                        n_ovf = 1'b1;
                    end else begin
                        wr_ser  = 1'b1;
                        wr_gran = 1'b1;
                        wr_addr = r_cnt[IW-1:0];
                        n_cnt   = r_cnt + CW'(1);
                    end
                end else begin
                    rd_en = 1'b1;
                end
            end
            T_LCMP: begin
                if (r_rd_serial == r_evt.serial) begin
                    wr_gran = 1'b1;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            T_MRD: begin
                rd_en = !at_end;
            end
            T_MCMP: begin
                if (r_rd_granule > r_max) begin
                    n_max = r_rd_granule;
                end
                n_idx = r_idx + CW'(1);
            end
            T_OVR: begin
                if (out_free) begin
                    n_ovalid                 = 1'b1;
                    n_res.stream_serial      = 32'd0;
                    n_res.duration_samples   = adjusted(r_max, i_start_granule);
                    n_res.is_overall         = 1'b1;
                    n_res.last_of_report     = (r_cnt == '0);
                    n_res.table_overflowed   = r_ovf;
                    n_res.parse_halted       = i_halted;
                    n_idx                    = '0;
                end
            end
            T_ERD: begin
                rd_en = 1'b1;
            end
            T_EOUT: begin
                if (out_free) begin
                    n_ovalid                 = 1'b1;
                    n_res.stream_serial      = r_rd_serial;
                    n_res.duration_samples   = adjusted(r_rd_granule, i_start_granule);
                    n_res.is_overall         = 1'b0;
                    n_res.last_of_report     = (r_idx + CW'(1) == r_cnt);
                    n_res.table_overflowed   = r_ovf;
                    n_res.parse_halted       = i_halted;
                    n_idx                    = r_idx + CW'(1);
                end
            end
            default: begin
                n_ovalid = r_ovalid && i_out_stall;
            end
        endcase
    end

    // Entry memories with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_ser) begin
            mem_serial[wr_addr] <= r_evt.serial;
        end
        if (wr_gran) begin
            mem_granule[wr_addr] <= r_evt.granule;
        end
        if (rd_en) begin
            r_rd_serial  <= mem_serial[r_idx[IW-1:0]];
            r_rd_granule <= mem_granule[r_idx[IW-1:0]];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_max <= n_max;
        r_evt <= n_evt;
        r_res <= n_res;
    end

    assign o_busy      = (r_state != T_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_result    = r_res;

endmodule

// ----- rtl/ogg_page_granule_tracker_unit.sv -----
// Top level of the Ogg page granule tracker.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+------------------------------------
//  input    | in        | i_in_valid / o_in_stall | i_cmd, i_byte_value
//  result   | out       | o_out_valid/ i_out_stall| serial, duration, flags
//
// A file byte is taken whenever the input is not stalled. The byte that ends a page
// of any stream but the metadata one starts a table lookup that compares each stored
// entry of the memory in turn, input stalled. A finish command scans for the maximum,
// then emits the overall result and one per entry while the output is not stalled.
// Reset is synchronous and active low; the entry memories need no clearing.
`timescale 1ns / 1ps
module ogg_page_granule_tracker_unit #(
    parameter int MAX_STREAMS     = ogpt_pkg::DEF_MAX_STREAMS,
    parameter int META_SCAN_LIMIT = ogpt_pkg::DEF_META_SCAN_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_byte_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_stream_serial,
    output logic [63:0] o_duration_samples,
    output logic        o_is_overall,
    output logic        o_last_of_report,
    output logic        o_table_overflowed,
    output logic        o_parse_halted
);
    import ogpt_pkg::*;

    logic        take;
    logic        busy;
    logic        evt_valid;
    t_page_evt   evt;
    logic [63:0] start_granule;
    logic        halted;
    t_result     result;

    // An input transfer happens when the input is valid and the table is idle.
    assign take       = i_in_valid && !busy;
    assign o_in_stall = busy;

    ogpt_parser #(
        .META_SCAN_LIMIT(META_SCAN_LIMIT)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take && i_cmd == CMD_BYTE),
        .i_byte         (i_byte_value),
        .o_evt_valid    (evt_valid),
        .o_evt          (evt),
        .o_start_granule(start_granule),
        .o_halted       (halted)
    );

    ogpt_table #(
        .MAX_STREAMS(MAX_STREAMS)
    ) u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_evt_valid    (evt_valid),
        .i_evt          (evt),
        .i_report       (take && i_cmd == CMD_FINISH),
        .i_start_granule(start_granule),
        .i_halted       (halted),
        .o_busy         (busy),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result       (result)
    );

    // Unpack the result register onto the output ports.
    assign o_stream_serial    = result.stream_serial;
    assign o_duration_samples = result.duration_samples;
    assign o_is_overall       = result.is_overall;
    assign o_last_of_report   = result.last_of_report;
    assign o_table_overflowed = result.table_overflowed;
    assign o_parse_halted     = result.parse_halted;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the Ogg page granule tracker.
`timescale 1ns / 1ps
module testbench;
    import ogpt_pkg::*;

    localparam int NSTREAMS   = DEF_MAX_STREAMS;
    localparam int SCAN_LIMIT = DEF_META_SCAN_LIMIT;

    // Predictor of the tracker plus the queue of expected report lines.
    class granule_scoreboard;
        t_phase      phase;
        logic [4:0]  cnt;
        logic [63:0] gran_sr;
        logic [31:0] ser_sr;
        logic [7:0]  segs_left;
        logic [16:0] pay_size;
        logic [16:0] pay_left;
        bit          tag_ok;
        bit          meta_seen;
        logic [31:0] meta_ser;
        logic [63:0] start_gran;
        bit          start_seen;
        bit          halt;
        logic [31:0] tbl_ser[NSTREAMS];
        logic [63:0] tbl_gran[NSTREAMS];
        bit          tbl_used[NSTREAMS];
        bit          ovf;
        t_result     pending[$];
        int          errors;

        function void clear();
            phase = PH_HEADER; cnt = 0; gran_sr = 0; ser_sr = 0; segs_left = 0;
            pay_size = 0; pay_left = 0; tag_ok = 0; meta_seen = 0; meta_ser = 0;
            start_gran = 0; start_seen = 0; halt = 0; ovf = 0;
            foreach (tbl_used[i]) tbl_used[i] = 0;
            pending.delete();
            errors = 0;
        endfunction

        function logic [63:0] span(logic [63:0] last);
            return (last > start_gran) ? last - start_gran : last;
        endfunction

        // Apply a completed page to the stream table.
        function void close_page();
            if (!meta_seen && tag_ok && pay_size >= TAG_MIN_PAYLOAD && pay_size < SCAN_LIMIT) begin
                meta_seen = 1;
                meta_ser = ser_sr;
            end
            if (!start_seen && gran_sr != 0) begin
                start_seen = 1;
                start_gran = gran_sr;
            end
            if (meta_seen && ser_sr == meta_ser) return;
            for (int i = 0; i < NSTREAMS; i++)
                if (tbl_used[i] && tbl_ser[i] == ser_sr) begin
                    tbl_gran[i] = gran_sr;
                    return;
                end
            for (int i = 0; i < NSTREAMS; i++)
                if (!tbl_used[i]) begin
                    tbl_used[i] = 1; tbl_ser[i] = ser_sr; tbl_gran[i] = gran_sr;
                    return;
                end
            ovf = 1;
        endfunction

        function void parse_byte(logic [7:0] b);
            if (halt) return;
            if (phase == PH_SEGMENTS) begin
                pay_size += b;
                segs_left -= 1;
                if (segs_left == 0) begin
                    cnt = 0;
                    if (pay_size == 0) phase = PH_HEADER;
                    else begin
                        pay_left = pay_size; tag_ok = 1; phase = PH_PAYLOAD;
                    end
                end
                return;
            end
            if (phase == PH_PAYLOAD) begin
                if (cnt < TAG_LEN) begin
                    if (b != ("ECMETA" >> (8 * (5 - cnt)) & 8'hFF)) tag_ok = 0;
                    cnt++;
                end
                pay_left -= 1;
                if (pay_left == 0) begin
                    close_page();
                    phase = PH_HEADER;
                    cnt = 0;
                end
                return;
            end
            if (cnt > HDR_LAST) cnt = 0;
            if (cnt < 4 && b != (32'h4F676753 >> (8 * (3 - cnt)) & 8'hFF)) begin
                halt = 1;
                return;
            end
            if (cnt >= 6 && cnt <= 13) gran_sr = {b, gran_sr[63:8]};
            else if (cnt >= 14 && cnt <= 17) ser_sr = {b, ser_sr[31:8]};
            if (cnt == HDR_LAST) begin
                cnt = 0; segs_left = b; pay_size = 0;
                if (b != 0) phase = PH_SEGMENTS;
                return;
            end
            cnt++;
        endfunction

        // Note one accepted input transfer.
        function void note_input(logic c, logic [7:0] b);
            t_result r;
            logic [63:0] top;
            int total, seen;
            if (c == CMD_BYTE) begin
                parse_byte(b);
                return;
            end
            top = 0; total = 0; seen = 0;
            foreach (tbl_used[i])
                if (tbl_used[i]) begin
                    total++;
                    if (tbl_gran[i] > top) top = tbl_gran[i];
                end
            r = '{32'd0, span(top), 1'b1, total == 0, ovf, halt};
            pending.push_back(r);
            foreach (tbl_used[i])
                if (tbl_used[i]) begin
                    seen++;
                    r = '{tbl_ser[i], span(tbl_gran[i]), 1'b0, seen == total, ovf, halt};
                    pending.push_back(r);
                end
        endfunction

        // Check one accepted result transfer against the oldest expectation.
        function void check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                $error("unexpected result serial %0h", got.stream_serial);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.stream_serial !== e.stream_serial) begin
                $error("stream_serial exp %0h got %0h", e.stream_serial, got.stream_serial);
                errors++;
            end
            if (got.duration_samples !== e.duration_samples) begin
                $error("duration_samples exp %0h got %0h", e.duration_samples,
                       got.duration_samples);
                errors++;
            end
            if (got.is_overall !== e.is_overall) begin
                $error("is_overall exp %0b got %0b", e.is_overall, got.is_overall);
                errors++;
            end
            if (got.last_of_report !== e.last_of_report) begin
                $error("last_of_report exp %0b got %0b", e.last_of_report, got.last_of_report);
                errors++;
            end
            if (got.table_overflowed !== e.table_overflowed) begin
                $error("table_overflowed exp %0b got %0b", e.table_overflowed,
                       got.table_overflowed);
                errors++;
            end
            if (got.parse_halted !== e.parse_halted) begin
                $error("parse_halted exp %0b got %0b", e.parse_halted, got.parse_halted);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        i_cmd = 0;
    logic [7:0]  i_byte_value = 0;
    logic        i_out_stall = 0;
    logic        o_in_stall, o_out_valid;
    logic [31:0] o_stream_serial;
    logic [63:0] o_duration_samples;
    logic        o_is_overall, o_last_of_report, o_table_overflowed, o_parse_halted;
    bit          stall_enable = 0;
    granule_scoreboard sb;

    ogg_page_granule_tracker_unit dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // Result side: random stall, check on every accepted transfer.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{o_stream_serial, o_duration_samples, o_is_overall,
                              o_last_of_report, o_table_overflowed, o_parse_halted});
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= 0;
            if (stall_enable) stall_left <= gap_len();
        end
    end

    // Drive one input transfer and wait for its acceptance.
    task automatic send(logic c, logic [7:0] b, bit idle_ok = 1);
        int g;
        g = idle_ok ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_cmd <= c;
        i_byte_value <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(c, b);
    endtask

    task automatic send_page(logic [31:0] ser, logic [63:0] gran, int nsegs,
                             int seg_max, bit meta, bit bad = 0);
        logic [7:0] segs[$];
        int total;
        total = 0;
        send(CMD_BYTE, bad ? 8'($urandom) : 8'h4F);
        send(CMD_BYTE, 8'h67); send(CMD_BYTE, 8'h67); send(CMD_BYTE, 8'h53);
        send(CMD_BYTE, 8'($urandom)); send(CMD_BYTE, 8'($urandom));
        for (int i = 0; i < 8; i++) send(CMD_BYTE, gran[8*i +: 8]);
        for (int i = 0; i < 4; i++) send(CMD_BYTE, ser[8*i +: 8]);
        for (int i = 18; i < 26; i++) send(CMD_BYTE, 8'($urandom));
        send(CMD_BYTE, 8'(nsegs));
        for (int i = 0; i < nsegs; i++) begin
            segs.push_back(8'($urandom_range(0, seg_max)));
            total += segs[i];
            send(CMD_BYTE, segs[i]);
        end
        for (int i = 0; i < total; i++)
            send(CMD_BYTE, (meta && i < 6) ? 8'("ECMETA" >> (8 * (5 - i))) : 8'($urandom));
    endtask

    task automatic finish_and_drain();
        send(CMD_FINISH, 8'($urandom));
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_serial();
        return ($urandom_range(0, 1) != 0) ? 32'($urandom_range(1, 20)) : $urandom;
    endfunction

    function automatic logic [63:0] pick_gran();
        case ($urandom_range(0, 4))
            0: return 64'd0;
            1: return '1;
            2: return {$urandom, $urandom};
            default: return 64'($urandom_range(1, 100000));
        endcase
    endfunction

    initial begin
        sb = new();
        sb.clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty table, empty pages, extremes, meta stream.
        finish_and_drain();
        stall_enable = 1;
        send_page(32'h0, 64'h0, 0, 0, 0);
        send_page(32'h5, 64'h10, 2, 0, 0);
        send_page(32'hFFFFFFFF, '1, 1, 3, 0);
        send_page(32'h0, 64'h0, 1, 2, 0);
        send_page(32'h7, 64'h20, 1, 8, 0);
        send_page(32'h7, 64'h30, 1, 10, 1);
        send_page(32'h7, 64'h40, 1, 5, 0);
        send_page(32'h8, 64'h8, 2, 4, 1);
        finish_and_drain();
        finish_and_drain();

        // A few random pages, each followed by a report.
        for (int n = 0; n < 2; n++) begin
            send_page(pick_serial(), pick_gran(), $urandom_range(0, 2), 6,
                      $urandom_range(0, 3) == 0);
            finish_and_drain();
        end

        // Report in the middle of a header, then a bad capture pattern.
        send(CMD_BYTE, 8'h4F);
        send(CMD_BYTE, 8'h67);
        finish_and_drain();
        send(CMD_BYTE, 8'h00);
        send(CMD_BYTE, 8'hFF);
        finish_and_drain();

        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/ogpt_pkg.sv
rtl/ogpt_parser.sv
rtl/ogpt_table.sv
rtl/ogg_page_granule_tracker_unit.sv
tb/testbench.sv
